### rtl/core/tes_pkg.sv
// Package for the triangle element stiffness block: widths, register indexes,
// and the structs passed between the front, queue, back and divider modules.
// No dependencies.
package tes_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int D_W        = 32;
    localparam int J_W        = COORD_BITS + 1;
    localparam int BC_W       = J_W + 1;
    localparam int PJ_W       = 2 * J_W;
    localparam int DET_W      = PJ_W + 1;
    localparam int DIV_W      = DET_W;
    localparam int M_W        = D_W + BC_W;
    localparam int DB_W       = M_W + 1;
    localparam int LO_W       = DB_W / 2;
    localparam int HI_W       = DB_W - LO_W;
    localparam int PH_W       = BC_W + HI_W;
    localparam int PL_W       = BC_W + LO_W + 1;
    localparam int S_W        = 2 * BC_W + D_W + 4;
    localparam int NUM_W      = S_W + FRAC_BITS;
    localparam int QUO_W      = 64;
    localparam int HIN_W      = NUM_W - QUO_W;
    localparam int VAL_W      = 64;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    localparam logic [IDX_W-1:0] DOF_LAST = IDX_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_D_XX = 3'd0,
        REG_D_XY = 3'd1,
        REG_D_XS = 3'd2,
        REG_D_YY = 3'd3,
        REG_D_YS = 3'd4,
        REG_D_SS = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [D_W-1:0] xx;
        logic signed [D_W-1:0] xy;
        logic signed [D_W-1:0] xs;
        logic signed [D_W-1:0] yy;
        logic signed [D_W-1:0] ys;
        logic signed [D_W-1:0] ss;
    } t_dmat;

    typedef struct packed {
        logic [2:0][BC_W-1:0]     b;
        logic [2:0][BC_W-1:0]     c;
        logic signed [DET_W-1:0]  det;
    } t_elem;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             sing;
        logic             last;
        logic             neg;
        logic             ovf;
        logic [DIV_W-1:0] div;
    } t_tag;

    typedef struct packed {
        logic             vld;
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] wq;
        t_tag             tag;
    } t_div_in;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    sing;
        logic                    last;
    } t_result;

endpackage

### rtl/core/tri3_element_stiffness.sv
// Constant-strain triangle stiffness matrix generator, top level.
// Holds the material registers and joins front, queue, back and divider.
// Depends on tes_pkg, tes_front, tes_queue, tes_back and tes_divider.
//
// Usage: load the six material entries through the write port (i_cfg_we,
// i_cfg_idx, i_cfg_data) while the block is idle; writes to an index above
// five are dropped. A request of three corner coordinates is taken when push
// is high and full is low. Each request yields 36 stiffness entries in
// row-major order; the oldest entry is on the result ports while empty is low
// and is taken when pop is high.
// A request passes in order the front registers, the element queue, the load
// of the back, the back multiply stages, the one-bit-per-stage divider and the
// result register. Entries leave at one per cycle while the receiver keeps
// taking them, a bound set by the single result channel. Up to four requests
// wait in the element queue. When the receiver stalls, the whole back pipeline
// holds; the front keeps taking requests until the queue is full. Reset clears
// all valid state and sets the material registers to zero.
module tri3_element_stiffness (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tes_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tes_pkg::D_W-1:0]           i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node0_x,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node0_y,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node1_x,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node1_y,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node2_x,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node2_y,
    output logic                              empty,
    input  logic                              pop,
    output logic [tes_pkg::IDX_W-1:0]         o_row_index,
    output logic [tes_pkg::IDX_W-1:0]         o_col_index,
    output logic signed [tes_pkg::VAL_W-1:0]  o_entry_value,
    output logic                              o_singular,
    output logic                              o_last_entry
);
    import tes_pkg::*;

    t_dmat              r_d;
    logic               s_push, s_pop, s_qvld, s_adv, s_ovld;
    t_elem              s_felem, s_qelem;
    logic [Q_CNT_W-1:0] s_qcnt;
    t_div_in            s_div;
    t_result            s_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_D_XX: r_d.xx <= i_cfg_data;
                REG_D_XY: r_d.xy <= i_cfg_data;
                REG_D_XS: r_d.xs <= i_cfg_data;
                REG_D_YY: r_d.yy <= i_cfg_data;
                REG_D_YS: r_d.ys <= i_cfg_data;
                REG_D_SS: r_d.ss <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tes_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_node0_x (i_node0_x),
        .i_node0_y (i_node0_y),
        .i_node1_x (i_node1_x),
        .i_node1_y (i_node1_y),
        .i_node2_x (i_node2_x),
        .i_node2_y (i_node2_y),
        .i_q_cnt   (s_qcnt),
        .o_push    (s_push),
        .o_elem    (s_felem)
    );

    tes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_elem  (s_felem),
        .i_pop   (s_pop),
        .o_elem  (s_qelem),
        .o_vld   (s_qvld),
        .o_cnt   (s_qcnt)
    );

    tes_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_elem     (s_qelem),
        .i_elem_vld (s_qvld),
        .o_elem_pop (s_pop),
        .i_dmat     (r_d),
        .i_adv      (s_adv),
        .o_div      (s_div)
    );

    tes_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (s_div),
        .pop     (pop),
        .o_adv   (s_adv),
        .o_vld   (s_ovld),
        .o_res   (s_res)
    );

    assign empty         = !s_ovld;
    assign o_row_index   = s_res.row;
    assign o_col_index   = s_res.col;
    assign o_entry_value = s_res.value;
    assign o_singular    = s_res.sing;
    assign o_last_entry  = s_res.last;

endmodule

### rtl/core/tes_queue.sv
// Short element queue between the front and the back of the stiffness block.
// Depends on tes_pkg.
module tes_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tes_pkg::t_elem    i_elem,
    input  logic              i_pop,
    output tes_pkg::t_elem    o_elem,
    output logic              o_vld,
    output logic [tes_pkg::Q_CNT_W-1:0] o_cnt
);
    import tes_pkg::*;

    t_elem               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;

    assign o_elem = r_mem[r_rd];
    assign o_vld  = (r_cnt != '0);
    assign o_cnt  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_elem;
        end
    end

endmodule

### rtl/core/tes_front.sv
// Front of the stiffness block: takes corner coordinates, forms the Jacobian,
// its determinant and the strain-displacement terms. Depends on tes_pkg.
module tes_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node0_x,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node0_y,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node1_x,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node1_y,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node2_x,
    input  logic signed [tes_pkg::COORD_BITS-1:0] i_node2_y,
    input  logic [tes_pkg::Q_CNT_W-1:0]      i_q_cnt,
    output logic                             o_push,
    output tes_pkg::t_elem                   o_elem
);
    import tes_pkg::*;

    logic                    r_v1;
    logic signed [J_W-1:0]   r_j00, r_j01, r_j10, r_j11;
    logic                    r_v2;
    logic signed [PJ_W-1:0]  r_pa, r_pb;
    logic [2:0][BC_W-1:0]    r_b, r_c;
    logic [Q_CNT_W:0]        s_used;
    logic                    s_acc;

    assign s_used = (Q_CNT_W+1)'(i_q_cnt) + (Q_CNT_W+1)'(r_v1) + (Q_CNT_W+1)'(r_v2);
    assign full   = (s_used >= (Q_CNT_W+1)'(Q_DEPTH));
    assign s_acc  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= s_acc;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_j00 <= J_W'(i_node1_x) - J_W'(i_node0_x);
            r_j01 <= J_W'(i_node1_y) - J_W'(i_node0_y);
            r_j10 <= J_W'(i_node2_x) - J_W'(i_node0_x);
            r_j11 <= J_W'(i_node2_y) - J_W'(i_node0_y);
        end
        if (r_v1) begin
            r_pa   <= r_j00 * r_j11;
            r_pb   <= r_j01 * r_j10;
            r_b[0] <= BC_W'(r_j01) - BC_W'(r_j11);
            r_b[1] <= BC_W'(r_j11);
            r_b[2] <= -BC_W'(r_j01);
            r_c[0] <= BC_W'(r_j10) - BC_W'(r_j00);
            r_c[1] <= -BC_W'(r_j10);
            r_c[2] <= BC_W'(r_j00);
        end
    end

    assign o_push     = r_v2;
    assign o_elem.b   = r_b;
    assign o_elem.c   = r_c;
    assign o_elem.det = DET_W'(r_pa) - DET_W'(r_pb);

endmodule

### rtl/core/tes_back.sv
// Back of the stiffness block: walks the 36 entries of each element and forms
// the signed numerator of every entry. Depends on tes_pkg.
module tes_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tes_pkg::t_elem     i_elem,
    input  logic               i_elem_vld,
    output logic               o_elem_pop,
    input  tes_pkg::t_dmat     i_dmat,
    input  logic               i_adv,
    output tes_pkg::t_div_in   o_div
);
    import tes_pkg::*;

    typedef struct packed {
        logic [2:0][BC_W-1:0] b;
        logic [2:0][BC_W-1:0] c;
        logic [DIV_W-1:0]     div;
        logic                 dneg;
        logic                 sing;
    } t_cur;

    t_cur               r_cur;
    logic               r_cur_vld;
    logic [IDX_W-1:0]   r_row, r_col;
    logic               s_issue, s_last, s_load;
    logic [DET_W-1:0]   s_abs;

    logic                   r0_vld;
    t_tag                   r0_tag;
    logic signed [BC_W-1:0] r0_p, r0_q, r0_e1, r0_e2;
    logic signed [D_W-1:0]  r0_da, r0_db, r0_dc, r0_dd;
    logic                   r1_vld;
    t_tag                   r1_tag;
    logic signed [BC_W-1:0] r1_p, r1_q;
    logic signed [M_W-1:0]  r1_m1, r1_m2, r1_m3, r1_m4;
    logic                   r2_vld;
    t_tag                   r2_tag;
    logic signed [BC_W-1:0] r2_p, r2_q;
    logic signed [DB_W-1:0] r2_dbp, r2_dbq;
    logic                   r3_vld;
    t_tag                   r3_tag;
    logic signed [PH_W-1:0] r3_ph, r3_qh;
    logic signed [PL_W-1:0] r3_pl, r3_ql;
    logic                   r4_vld;
    t_tag                   r4_tag;
    logic signed [S_W-1:0]  r4_s;
    logic                   r5_vld;
    t_tag                   r5_tag;
    logic [DIV_W-1:0]       r5_rem;
    logic [QUO_W-1:0]       r5_wq;

    logic signed [S_W-1:0]  s_hsum;
    logic [S_W-1:0]         s_mag;
    logic [NUM_W-1:0]       s_num;
    logic [HIN_W-1:0]       s_hin;
    logic [1:0]             s_kr, s_mc;
    logic                   s_rodd, s_codd;
    t_tag                   s_tag5;

    assign s_last     = (r_row == DOF_LAST) && (r_col == DOF_LAST);
    assign s_issue    = i_adv && r_cur_vld;
    assign s_load     = i_elem_vld && (!r_cur_vld || (s_issue && s_last));
    assign o_elem_pop = s_load;
    assign s_abs      = i_elem.det[DET_W-1] ? DET_W'(-i_elem.det) : DET_W'(i_elem.det);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
        end else if (s_load) begin
            r_cur_vld <= 1'b1;
            r_row     <= '0;
            r_col     <= '0;
        end else if (s_issue) begin
            if (s_last) begin
                r_cur_vld <= 1'b0;
            end else if (r_col == DOF_LAST) begin
                r_col <= '0;
                r_row <= r_row + IDX_W'(1);
            end else begin
                r_col <= r_col + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_cur.b    <= i_elem.b;
            r_cur.c    <= i_elem.c;
            r_cur.div  <= {s_abs[DET_W-2:0], 1'b0};
            r_cur.dneg <= i_elem.det[DET_W-1];
            r_cur.sing <= (i_elem.det == '0);
        end
    end

    assign s_kr   = r_row[2:1];
    assign s_mc   = r_col[2:1];
    assign s_rodd = r_row[0];
    assign s_codd = r_col[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_adv) begin
            r0_vld <= s_issue;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_comb begin
        s_tag5     = r4_tag;
        s_tag5.neg = r4_s[S_W-1] ^ r4_tag.neg;
        s_tag5.ovf = (S_W'(s_hin) >= S_W'(r4_tag.div));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r0_tag.row  <= r_row;
            r0_tag.col  <= r_col;
            r0_tag.sing <= r_cur.sing;
            r0_tag.last <= s_last;
            r0_tag.neg  <= r_cur.dneg;
            r0_tag.ovf  <= 1'b0;
            r0_tag.div  <= r_cur.div;
            r0_p  <= s_rodd ? signed'(r_cur.c[s_kr]) : signed'(r_cur.b[s_kr]);
            r0_q  <= s_rodd ? signed'(r_cur.b[s_kr]) : signed'(r_cur.c[s_kr]);
            r0_e1 <= s_codd ? signed'(r_cur.c[s_mc]) : signed'(r_cur.b[s_mc]);
            r0_e2 <= s_codd ? signed'(r_cur.b[s_mc]) : signed'(r_cur.c[s_mc]);
            r0_da <= s_rodd ? (s_codd ? i_dmat.yy : i_dmat.xy)
                            : (s_codd ? i_dmat.xy : i_dmat.xx);
            r0_db <= s_rodd ? i_dmat.ys : i_dmat.xs;
            r0_dc <= s_codd ? i_dmat.ys : i_dmat.xs;
            r0_dd <= i_dmat.ss;

            r1_tag <= r0_tag;
            r1_p   <= r0_p;
            r1_q   <= r0_q;
            r1_m1  <= r0_da * r0_e1;
            r1_m2  <= r0_db * r0_e2;
            r1_m3  <= r0_dc * r0_e1;
            r1_m4  <= r0_dd * r0_e2;

            r2_tag <= r1_tag;
            r2_p   <= r1_p;
            r2_q   <= r1_q;
            r2_dbp <= DB_W'(r1_m1) + DB_W'(r1_m2);
            r2_dbq <= DB_W'(r1_m3) + DB_W'(r1_m4);

            r3_tag <= r2_tag;
            r3_ph  <= r2_p * signed'(r2_dbp[DB_W-1:LO_W]);
            r3_pl  <= r2_p * signed'({1'b0, r2_dbp[LO_W-1:0]});
            r3_qh  <= r2_q * signed'(r2_dbq[DB_W-1:LO_W]);
            r3_ql  <= r2_q * signed'({1'b0, r2_dbq[LO_W-1:0]});

            r4_tag <= r3_tag;
            r4_s   <= (s_hsum <<< LO_W) + S_W'(r3_pl) + S_W'(r3_ql);

            r5_tag <= s_tag5;
            r5_rem <= DIV_W'(s_hin);
            r5_wq  <= s_num[QUO_W-1:0];
        end
    end

    assign s_hsum = S_W'(r3_ph) + S_W'(r3_qh);
    assign s_mag  = r4_s[S_W-1] ? S_W'(-r4_s) : S_W'(r4_s);
    assign s_num  = NUM_W'(s_mag) << FRAC_BITS;
    assign s_hin  = s_num[NUM_W-1:QUO_W];
    assign o_div  = {r5_vld, r5_rem, r5_wq, r5_tag};

endmodule

### rtl/core/tes_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation and
// the result register. Depends on tes_pkg.
module tes_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tes_pkg::t_div_in   i_div,
    input  logic               pop,
    output logic               o_adv,
    output logic               o_vld,
    output tes_pkg::t_result   o_res
);
    import tes_pkg::*;

    logic [DIV_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_wq  [QUO_W];
    t_tag             r_tag [QUO_W];
    logic             r_vld [QUO_W];
    logic             r_out_vld;
    t_result          r_out;

    logic [QUO_W-1:0]        s_q;
    t_tag                    s_ft;
    logic                    s_big;
    logic signed [VAL_W-1:0] s_val;

    assign o_adv = !r_out_vld || pop;

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [DIV_W-1:0] s_rem;
        logic [QUO_W-1:0] s_wq;
        t_tag             s_tag;
        logic             s_vld;
        logic [DIV_W:0]   s_try;
        logic             s_ge;

        if (g == 0) begin : g_first
            assign s_rem = i_div.rem;
            assign s_wq  = i_div.wq;
            assign s_tag = i_div.tag;
            assign s_vld = i_div.vld;
        end else begin : g_next
            assign s_rem = r_rem[g-1];
            assign s_wq  = r_wq[g-1];
            assign s_tag = r_tag[g-1];
            assign s_vld = r_vld[g-1];
        end

        assign s_try = {s_rem, s_wq[QUO_W-1]};
        assign s_ge  = (s_try >= {1'b0, s_tag.div});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (o_adv) begin
                r_vld[g] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (o_adv) begin
                r_rem[g] <= s_ge ? DIV_W'(s_try - {1'b0, s_tag.div}) : DIV_W'(s_try);
                r_wq[g]  <= {s_wq[QUO_W-2:0], s_ge};
                r_tag[g] <= s_tag;
            end
        end
    end

    assign s_q   = r_wq[QUO_W-1];
    assign s_ft  = r_tag[QUO_W-1];
    assign s_big = s_ft.ovf || (s_q[QUO_W-1] && (!s_ft.neg || (s_q[QUO_W-2:0] != '0)));

    always_comb begin
        if (s_ft.sing) begin
            s_val = '0;
        end else if (s_big) begin
            s_val = s_ft.neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else if (s_ft.neg) begin
            s_val = VAL_W'(-s_q);
        end else begin
            s_val = VAL_W'(s_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= r_vld[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_vld[QUO_W-1]) begin
            r_out.row   <= s_ft.row;
            r_out.col   <= s_ft.col;
            r_out.value <= s_val;
            r_out.sing  <= s_ft.sing;
            r_out.last  <= s_ft.last;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_out;

endmodule
